// ===== sv/rrts_pkg.sv =====
// shared constants, codes and types for the round robin thread scheduler
package rrts_pkg;

  localparam int unsigned THREADS = 16;
  localparam int unsigned TID_W   = 4;
  localparam int unsigned CNT_W   = 5;

  // command codes
  localparam logic [2:0] CMD_CREATE = 3'd0;
  localparam logic [2:0] CMD_YIELD  = 3'd1;
  localparam logic [2:0] CMD_FINISH = 3'd2;
  localparam logic [2:0] CMD_JOIN   = 3'd3;
  localparam logic [2:0] CMD_DETACH = 3'd4;
  localparam logic [2:0] CMD_CANCEL = 3'd5;

  typedef enum logic [2:0] {
    RES_OK        = 3'd0,
    RES_NO_SLOT   = 3'd1,
    RES_NO_THREAD = 3'd2,
    RES_INVALID   = 3'd3,
    RES_BLOCKED   = 3'd4,
    RES_Q_EMPTY   = 3'd5
  } res_e;

  typedef enum logic [2:0] {
    TS_AVAIL    = 3'd0,
    TS_BLOCKED  = 3'd1,
    TS_CREATED  = 3'd2,
    TS_FINISHED = 3'd3,
    TS_READY    = 3'd4,
    TS_RUNNING  = 3'd5,
    TS_WAITING  = 3'd6
  } tstate_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_RS_CUR,
    S_RS_WAKE,
    S_RS_REL,
    S_RS_POP,
    S_RS_HEAD,
    S_RS_END,
    S_JOIN,
    S_DETACH,
    S_CANCEL,
    S_CAN_FIND,
    S_CAN_CLR,
    S_DONE
  } seq_e;

  // ready queue control: push at tail, or shift entries down from a position
  typedef struct packed {
    logic             push;
    logic [TID_W-1:0] push_id;
    logic             shift;
    logic [TID_W-1:0] shift_from;
  } qctl_t;

endpackage

// ===== sv/rrts_if.sv =====
// valid/ready channel interfaces for commands and results
interface rrts_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [3:0] target_thread;

  modport source (output valid, output cmd, output target_thread, input ready);
  modport sink (input valid, input cmd, input target_thread, output ready);
endinterface

interface rrts_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] new_thread;
  logic [3:0] running_thread;
  logic       fresh_start;
  logic       switched;

  modport source (output valid, output status, output new_thread,
                  output running_thread, output fresh_start, output switched,
                  input ready);
  modport sink (input valid, input status, input new_thread,
                input running_thread, input fresh_start, input switched,
                output ready);
endinterface

// ===== sv/round_robin_thread_scheduler.sv =====
// round robin thread scheduler: thread tables and command sequencer
//
// Commands enter on in_i (cmd, target_thread) and each yields exactly one
// result on out_o (status, new_thread, running_thread, fresh_start,
// switched). Both channels transfer a transaction when valid and ready are
// high at a rising edge of clk_i.
// One command is handled at a time by a sequencer that reads one thread table
// entry per cycle. Create scans the table for a free slot, and cancel of
// another thread searches the queue, then makes a pass that clears joiners.
// The next command is taken once the sequencer is back in idle.
// The result sits in an output register; while the receiver stalls, the
// next command may be accepted and processed, and the sequencer then waits
// until the register is free.
// Reset (rst_ni low, asynchronous) leaves thread 0 running, all other slots
// free, no joiners, no detached threads and an empty ready queue.
module round_robin_thread_scheduler (
  input  logic             clk_i,
  input  logic             rst_ni,
  rrts_in_if.sink          in_i,
  rrts_out_if.source       out_o
);

  localparam int unsigned TW = rrts_pkg::TID_W;

  rrts_pkg::seq_e    state_q, state_d;
  logic [2:0]        cmd_q, cmd_d;
  logic [TW-1:0]     tgt_q, tgt_d;
  logic [TW-1:0]     cur_q, cur_d;
  logic [TW-1:0]     nxt_q, nxt_d;
  logic [TW-1:0]     jn_q, jn_d;
  logic [TW-1:0]     made_q, made_d;
  logic [rrts_pkg::CNT_W-1:0] idx_q, idx_d;
  rrts_pkg::res_e    res_q, res_d;
  logic              fresh_q, fresh_d;
  logic              sw_q, sw_d;

  // thread tables
  rrts_pkg::tstate_e ts_q [rrts_pkg::THREADS];
  logic              det_q [rrts_pkg::THREADS];
  logic              jv_q [rrts_pkg::THREADS];
  logic [TW-1:0]     jid_q [rrts_pkg::THREADS];

  logic              ts_we, det_we, jv_we, jid_we;
  logic [TW-1:0]     ts_wa, det_wa, jv_wa, jid_wa, ra;
  rrts_pkg::tstate_e ts_wd, ts_rd;
  logic              det_wd, jv_wd, det_rd, jv_rd;
  logic [TW-1:0]     jid_wd, jid_rd;

  // queue
  rrts_pkg::qctl_t   qctl;
  logic [TW-1:0]     q_head, q_rd;
  logic [rrts_pkg::CNT_W-1:0] q_count;

  // output register
  logic              out_valid_q, out_load;
  rrts_pkg::res_e    out_res_q;
  logic [TW-1:0]     out_made_q, out_cur_q;
  logic              out_fresh_q, out_sw_q;

  rrts_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (qctl),
    .rd_idx_i  (idx_q[TW-1:0]),
    .head_o    (q_head),
    .rd_data_o (q_rd),
    .count_o   (q_count)
  );

  // shared table read port
  assign ts_rd  = ts_q[ra];
  assign det_rd = det_q[ra];
  assign jv_rd  = jv_q[ra];
  assign jid_rd = jid_q[ra];

  // sequencer next state and table controls
  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    tgt_d    = tgt_q;
    cur_d    = cur_q;
    nxt_d    = nxt_q;
    jn_d     = jn_q;
    made_d   = made_q;
    idx_d    = idx_q;
    res_d    = res_q;
    fresh_d  = fresh_q;
    sw_d     = sw_q;
    ts_we    = 1'b0;
    ts_wa    = cur_q;
    ts_wd    = rrts_pkg::TS_AVAIL;
    det_we   = 1'b0;
    det_wa   = tgt_q;
    det_wd   = 1'b0;
    jv_we    = 1'b0;
    jv_wa    = tgt_q;
    jv_wd    = 1'b0;
    jid_we   = 1'b0;
    jid_wa   = tgt_q;
    jid_wd   = '0;
    ra       = cur_q;
    qctl     = '0;
    in_i.ready = 1'b0;
    out_load = 1'b0;

    unique case (state_q)
      rrts_pkg::S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          cmd_d   = in_i.cmd;
          tgt_d   = in_i.target_thread;
          res_d   = rrts_pkg::RES_OK;
          made_d  = '0;
          fresh_d = 1'b0;
          sw_d    = 1'b0;
          state_d = rrts_pkg::S_DECODE;
        end
      end

      rrts_pkg::S_DECODE: begin
        unique case (cmd_q)
          rrts_pkg::CMD_CREATE: begin
            idx_d   = rrts_pkg::CNT_W'(1);
            state_d = rrts_pkg::S_SCAN;
          end
          rrts_pkg::CMD_YIELD: state_d = rrts_pkg::S_RS_CUR;
          rrts_pkg::CMD_FINISH: begin
            ts_we   = 1'b1;
            ts_wd   = rrts_pkg::TS_FINISHED;
            state_d = rrts_pkg::S_RS_CUR;
          end
          rrts_pkg::CMD_JOIN:   state_d = rrts_pkg::S_JOIN;
          rrts_pkg::CMD_DETACH: state_d = rrts_pkg::S_DETACH;
          rrts_pkg::CMD_CANCEL: state_d = rrts_pkg::S_CANCEL;
          default: begin
            res_d   = rrts_pkg::RES_INVALID;
            state_d = rrts_pkg::S_DONE;
          end
        endcase
      end

      // lowest free slot from 1 upward
      rrts_pkg::S_SCAN: begin
        ra = idx_q[TW-1:0];
        if (ts_rd == rrts_pkg::TS_AVAIL) begin
          ts_we        = 1'b1;
          ts_wa        = idx_q[TW-1:0];
          ts_wd        = rrts_pkg::TS_CREATED;
          det_we       = 1'b1;
          det_wa       = idx_q[TW-1:0];
          jv_we        = 1'b1;
          jv_wa        = idx_q[TW-1:0];
          jid_we       = 1'b1;
          jid_wa       = idx_q[TW-1:0];
          qctl.push    = 1'b1;
          qctl.push_id = idx_q[TW-1:0];
          made_d       = idx_q[TW-1:0];
          state_d      = rrts_pkg::S_DONE;
        end else if (idx_q == rrts_pkg::CNT_W'(rrts_pkg::THREADS - 1)) begin
          res_d   = rrts_pkg::RES_NO_SLOT;
          state_d = rrts_pkg::S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // retire the current thread
      rrts_pkg::S_RS_CUR: begin
        state_d = rrts_pkg::S_RS_POP;
        if (ts_rd == rrts_pkg::TS_RUNNING) begin
          ts_we        = 1'b1;
          ts_wd        = rrts_pkg::TS_READY;
          qctl.push    = 1'b1;
          qctl.push_id = cur_q;
        end else if (ts_rd == rrts_pkg::TS_FINISHED) begin
          if (det_rd) begin
            ts_we = 1'b1;
          end else if (jv_rd) begin
            jv_we   = 1'b1;
            jv_wa   = cur_q;
            jn_d    = jid_rd;
            state_d = rrts_pkg::S_RS_WAKE;
          end
        end
      end

      rrts_pkg::S_RS_WAKE: begin
        ts_we        = 1'b1;
        ts_wa        = jn_q;
        ts_wd        = rrts_pkg::TS_READY;
        qctl.push    = 1'b1;
        qctl.push_id = jn_q;
        state_d      = rrts_pkg::S_RS_REL;
      end

      rrts_pkg::S_RS_REL: begin
        ts_we   = 1'b1;
        state_d = rrts_pkg::S_RS_POP;
      end

      rrts_pkg::S_RS_POP: begin
        if (q_count == '0) begin
          res_d   = rrts_pkg::RES_Q_EMPTY;
          state_d = rrts_pkg::S_RS_END;
        end else begin
          nxt_d      = q_head;
          qctl.shift = 1'b1;
          state_d    = rrts_pkg::S_RS_HEAD;
        end
      end

      rrts_pkg::S_RS_HEAD: begin
        ra      = nxt_q;
        ts_wa   = nxt_q;
        ts_wd   = rrts_pkg::TS_RUNNING;
        state_d = rrts_pkg::S_RS_END;
        if (ts_rd == rrts_pkg::TS_CREATED || ts_rd == rrts_pkg::TS_READY) begin
          ts_we   = 1'b1;
          cur_d   = nxt_q;
          fresh_d = (ts_rd == rrts_pkg::TS_CREATED);
          res_d   = rrts_pkg::RES_OK;
        end else begin
          res_d = rrts_pkg::RES_INVALID;
        end
      end

      rrts_pkg::S_RS_END: begin
        if (res_q == rrts_pkg::RES_OK) begin
          sw_d = 1'b1;
          if (cmd_q == rrts_pkg::CMD_JOIN) begin
            res_d = rrts_pkg::RES_BLOCKED;
          end
        end
        state_d = rrts_pkg::S_DONE;
      end

      rrts_pkg::S_JOIN: begin
        ra      = tgt_q;
        state_d = rrts_pkg::S_DONE;
        if (tgt_q == '0 || ts_rd == rrts_pkg::TS_AVAIL) begin
          res_d = rrts_pkg::RES_NO_THREAD;
        end else if (det_rd || jv_rd) begin
          res_d = rrts_pkg::RES_INVALID;
        end else if (ts_rd == rrts_pkg::TS_FINISHED) begin
          ts_we = 1'b1;
          ts_wa = tgt_q;
        end else begin
          ts_we   = 1'b1;
          ts_wd   = rrts_pkg::TS_WAITING;
          jv_we   = 1'b1;
          jv_wd   = 1'b1;
          jid_we  = 1'b1;
          jid_wd  = cur_q;
          state_d = rrts_pkg::S_RS_CUR;
        end
      end

      rrts_pkg::S_DETACH: begin
        ra      = tgt_q;
        ts_wa   = tgt_q;
        det_wd  = 1'b1;
        state_d = rrts_pkg::S_DONE;
        if (tgt_q == '0) begin
          res_d = rrts_pkg::RES_NO_THREAD;
        end else if (!det_rd) begin
          det_we = 1'b1;
          ts_we  = (ts_rd == rrts_pkg::TS_FINISHED);
        end
      end

      rrts_pkg::S_CANCEL: begin
        ra = tgt_q;
        if (tgt_q == '0 || ts_rd == rrts_pkg::TS_AVAIL) begin
          res_d   = rrts_pkg::RES_NO_THREAD;
          state_d = rrts_pkg::S_DONE;
        end else if (tgt_q == cur_q) begin
          ts_we   = 1'b1;
          ts_wd   = rrts_pkg::TS_FINISHED;
          det_we  = 1'b1;
          det_wd  = 1'b1;
          state_d = rrts_pkg::S_RS_CUR;
        end else begin
          idx_d   = '0;
          state_d = rrts_pkg::S_CAN_FIND;
        end
      end

      // search the queue for the target and close the gap
      rrts_pkg::S_CAN_FIND: begin
        if (idx_q >= q_count) begin
          idx_d   = '0;
          state_d = rrts_pkg::S_CAN_CLR;
        end else if (q_rd == tgt_q) begin
          qctl.shift      = 1'b1;
          qctl.shift_from = idx_q[TW-1:0];
          idx_d           = '0;
          state_d         = rrts_pkg::S_CAN_CLR;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // clear every joiner that names the target, then free it
      rrts_pkg::S_CAN_CLR: begin
        ra     = idx_q[TW-1:0];
        jv_wa  = idx_q[TW-1:0];
        jid_wa = idx_q[TW-1:0];
        if (jv_rd && jid_rd == tgt_q) begin
          jv_we  = 1'b1;
          jid_we = 1'b1;
        end
        if (idx_q == rrts_pkg::CNT_W'(rrts_pkg::THREADS - 1)) begin
          ts_we   = 1'b1;
          ts_wa   = tgt_q;
          state_d = rrts_pkg::S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      rrts_pkg::S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = rrts_pkg::S_IDLE;
        end
      end

      default: state_d = rrts_pkg::S_IDLE;
    endcase
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrts_pkg::S_IDLE;
      cur_q   <= '0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    tgt_q   <= tgt_d;
    nxt_q   <= nxt_d;
    jn_q    <= jn_d;
    made_q  <= made_d;
    idx_q   <= idx_d;
    res_q   <= res_d;
    fresh_q <= fresh_d;
    sw_q    <= sw_d;
  end

  // thread tables, one write per table per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rrts_pkg::THREADS; i++) begin
        ts_q[i]  <= (i == 0) ? rrts_pkg::TS_RUNNING : rrts_pkg::TS_AVAIL;
        det_q[i] <= 1'b0;
        jv_q[i]  <= 1'b0;
        jid_q[i] <= '0;
      end
    end else begin
      if (ts_we) begin
        ts_q[ts_wa] <= ts_wd;
      end
      if (det_we) begin
        det_q[det_wa] <= det_wd;
      end
      if (jv_we) begin
        jv_q[jv_wa] <= jv_wd;
      end
      if (jid_we) begin
        jid_q[jid_wa] <= jid_wd;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_load | (out_valid_q & ~out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q   <= res_q;
      out_made_q  <= made_q;
      out_cur_q   <= cur_q;
      out_fresh_q <= fresh_q;
      out_sw_q    <= sw_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_res_q;
  assign out_o.new_thread     = out_made_q;
  assign out_o.running_thread = out_cur_q;
  assign out_o.fresh_start    = out_fresh_q;
  assign out_o.switched       = out_sw_q;

`ifndef SYNTHESIS
  a_qcount_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= rrts_pkg::CNT_W'(rrts_pkg::THREADS))
    else $error("ready queue count beyond capacity");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != rrts_pkg::S_IDLE) |-> !in_i.ready)
    else $error("command taken while busy");

  a_fresh_implies_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_fresh_q) |-> out_sw_q)
    else $error("fresh start without a switch");

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == rrts_pkg::S_DECODE))
    else $error("accepted command not decoded");

  a_switch_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_sw_q) |->
      (out_res_q == rrts_pkg::RES_OK || out_res_q == rrts_pkg::RES_BLOCKED))
    else $error("switch reported with an error status");
`endif

endmodule

// ===== sv/rrts_queue.sv =====
// fifo ready queue of thread ids with tail push and shift-down removal
module rrts_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rrts_pkg::qctl_t             ctl_i,
  input  logic [rrts_pkg::TID_W-1:0]  rd_idx_i,
  output logic [rrts_pkg::TID_W-1:0]  head_o,
  output logic [rrts_pkg::TID_W-1:0]  rd_data_o,
  output logic [rrts_pkg::CNT_W-1:0]  count_o
);

  logic [rrts_pkg::TID_W-1:0] q_q [rrts_pkg::THREADS];
  logic [rrts_pkg::CNT_W-1:0] count_q, count_d;
  logic                       full;

  assign full      = (count_q == rrts_pkg::CNT_W'(rrts_pkg::THREADS));
  assign head_o    = q_q[0];
  assign rd_data_o = q_q[rd_idx_i];
  assign count_o   = count_q;

  // fill count
  always_comb begin
    count_d = count_q;
    if (ctl_i.push && !full) begin
      count_d = count_q + 1'b1;
    end else if (ctl_i.shift) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // entries: shift down from a position, or write at the tail
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < rrts_pkg::THREADS - 1; j++) begin
      if (ctl_i.shift && (rrts_pkg::TID_W'(j) >= ctl_i.shift_from)) begin
        q_q[j] <= q_q[j+1];
      end
    end
    if (ctl_i.push && !full) begin
      q_q[count_q[rrts_pkg::TID_W-1:0]] <= ctl_i.push_id;
    end
  end

endmodule
